>>> rtl/lgs_pkg.sv
// shared types, constants and the cell rule for the life generation step block
// no dependencies
`default_nettype none

package lgs_pkg;

	localparam int MAX_WIDTH_DEF  = 64;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int REG_W     = 7;
	localparam int ACTION_W  = 2;
	localparam int COORD_W   = 6;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 8;
	localparam int CFG_ADDR_W = 1;

	localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [REG_W-1:0] GRID_SIZE_RESET = 7'd64;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	typedef struct packed {
		logic load;
		logic decode;
		logic acc_rd;
		logic acc_mod;
		logic sweep_start;
		logic sweep_rd;
		logic flush;
		logic out_load;
	} lgs_cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic                oor;
		logic                grid_empty;
		logic                rd_last;
	} lgs_sts_t;

	// b3/s23 on a 3x3 neighborhood, center is mid[1]
	function automatic logic life_next(logic [2:0] up, logic [2:0] mid, logic [2:0] dn);
		logic [3:0] n;
		n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
			+ 4'(dn[0]) + 4'(dn[1]) + 4'(dn[2]);
		return (n == BIRTH_COUNT) || ((n == SURVIVE_COUNT) && mid[1]);
	endfunction

endpackage

`default_nettype wire

>>> rtl/lgs_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/lgs_datapath.sv
// datapath: config registers, cell row memory, three-row sweep window, result registers
// depends on lgs_pkg and lgs_ram
`default_nettype none

module lgs_datapath #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [lgs_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [lgs_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [lgs_pkg::REG_W-1:0]       cfg_data,
	input  wire lgs_pkg::lgs_cmd_t               cmd,
	output lgs_pkg::lgs_sts_t                    sts,
	output logic [lgs_pkg::M_TDATA_W-1:0]        m_tdata
);
	import lgs_pkg::*;

	localparam int RAW = $clog2(MAX_HEIGHT);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WCW = ($clog2(MAX_WIDTH + 1) > REG_W) ? $clog2(MAX_WIDTH + 1) : REG_W;
	localparam int HCW = ($clog2(MAX_HEIGHT + 1) > REG_W) ? $clog2(MAX_HEIGHT + 1) : REG_W;

	logic [REG_W-1:0]    width_q, height_q;
	logic [WCW-1:0]      act_w;
	logic [HCW-1:0]      act_h;
	logic [MAX_WIDTH-1:0] colmask;

	logic [ACTION_W-1:0] action_q;
	logic [COORD_W-1:0]  row_q, col_q;
	logic                alive_q;
	logic [CW-1:0]       col_idx;
	logic [RAW-1:0]      row_addr;

	logic [MAX_HEIGHT-1:0] row_valid_q;
	logic                  valid_s1;
	logic                  sweep_s1;
	logic [RAW-1:0]        rc_q, wc_q;
	logic                  have_cur_q;
	logic [MAX_WIDTH-1:0]  prev_q, cur_q;

	logic                 rd_en;
	logic [RAW-1:0]       rd_addr;
	logic [MAX_WIDTH-1:0] ram_rd;
	logic [MAX_WIDTH-1:0] rd_row;
	logic [MAX_WIDTH-1:0] inc_row;
	logic [MAX_WIDTH-1:0] next_row;
	logic [MAX_WIDTH-1:0] merged_row;
	logic                 shift_en;
	logic                 acc_wr;
	logic                 wr_en;
	logic [RAW-1:0]       wr_addr;
	logic [MAX_WIDTH-1:0] wr_data;

	logic res_alive_q, res_oor_q;
	logic out_alive_q, out_oor_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GRID_SIZE_RESET;
			height_q <= GRID_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GRID_WIDTH:  width_q  <= cfg_data;
				REG_GRID_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign act_w = (WCW'(width_q) > WCW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(width_q);
	assign act_h = (HCW'(height_q) > HCW'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : HCW'(height_q);

	always_comb begin
		for (int c = 0; c < MAX_WIDTH; c++) begin
			colmask[c] = (WCW'(c) < act_w);
		end
	end

	// item fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= s_tdata[1:0];
			row_q    <= s_tdata[7:2];
			col_q    <= s_tdata[13:8];
			alive_q  <= s_tdata[14];
		end
	end

	assign col_idx  = CW'(col_q);
	assign row_addr = RAW'(row_q);

	assign sts.action     = action_q;
	assign sts.oor        = (HCW'(row_q) >= act_h) || (WCW'(col_q) >= act_w);
	assign sts.grid_empty = (act_w == '0) || (act_h == '0);
	assign sts.rd_last    = ((HCW'(rc_q) + HCW'(1)) == act_h);

	// row memory with per-row valid bits, so reset needs no clearing pass
	assign rd_en   = cmd.acc_rd || cmd.sweep_rd;
	assign rd_addr = cmd.sweep_rd ? rc_q : row_addr;

	lgs_ram #(
		.WIDTH(MAX_WIDTH),
		.DEPTH(MAX_HEIGHT)
	) u_rows (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	assign rd_row = valid_s1 ? ram_rd : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			valid_s1    <= 1'b0;
			sweep_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				valid_s1 <= row_valid_q[rd_addr];
			end
			sweep_s1 <= cmd.sweep_rd;
		end
	end

	// sweep window: prev and cur hold old rows, inc_row is the row below
	assign shift_en = sweep_s1 || cmd.flush;
	assign inc_row  = cmd.flush ? '0 : rd_row;

	always_comb begin
		logic [MAX_WIDTH+1:0] pm, cm, xm;
		pm = {1'b0, prev_q & colmask, 1'b0};
		cm = {1'b0, cur_q & colmask, 1'b0};
		xm = {1'b0, inc_row & colmask, 1'b0};
		for (int c = 0; c < MAX_WIDTH; c++) begin
			next_row[c] = colmask[c] ? life_next(pm[c +: 3], cm[c +: 3], xm[c +: 3]) : cur_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q       <= '0;
			wc_q       <= '0;
			have_cur_q <= 1'b0;
		end else if (cmd.sweep_start) begin
			rc_q       <= '0;
			wc_q       <= '0;
			have_cur_q <= 1'b0;
		end else begin
			if (cmd.sweep_rd) begin
				rc_q <= rc_q + RAW'(1);
			end
			if (shift_en) begin
				have_cur_q <= 1'b1;
				if (have_cur_q) begin
					wc_q <= wc_q + RAW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			prev_q <= '0;
			cur_q  <= '0;
		end else if (shift_en) begin
			prev_q <= cur_q;
			cur_q  <= inc_row;
		end
	end

	// single cell write merges into the fetched row
	always_comb begin
		merged_row          = rd_row;
		merged_row[col_idx] = alive_q;
	end

	assign acc_wr  = cmd.acc_mod && (action_q == ACT_WRITE);
	assign wr_en   = acc_wr || (shift_en && have_cur_q);
	assign wr_addr = acc_wr ? row_addr : wc_q;
	assign wr_data = acc_wr ? merged_row : next_row;

	// result
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			res_alive_q <= 1'b0;
			res_oor_q   <= sts.oor && ((action_q == ACT_WRITE) || (action_q == ACT_READ));
		end else if (cmd.acc_mod) begin
			res_alive_q <= (action_q == ACT_WRITE) ? alive_q : rd_row[col_idx];
		end
		if (cmd.out_load) begin
			out_alive_q <= res_alive_q;
			out_oor_q   <= res_oor_q;
		end
	end

	assign m_tdata = {{(M_TDATA_W - 2){1'b0}}, out_oor_q, out_alive_q};

endmodule

`default_nettype wire

>>> rtl/lgs_ctrl.sv
// controller state machine: stream handshakes and sequencing of access and sweep
// depends on lgs_pkg
`default_nettype none

module lgs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire lgs_pkg::lgs_sts_t sts,
	output lgs_pkg::lgs_cmd_t      cmd
);
	import lgs_pkg::*;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DECODE    = 3'd1;
	localparam logic [2:0] ST_ACC_MOD   = 3'd2;
	localparam logic [2:0] ST_ADV_RD    = 3'd3;
	localparam logic [2:0] ST_ADV_DRAIN = 3'd4;
	localparam logic [2:0] ST_ADV_FLUSH = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       is_access;

	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign is_access = (sts.action == ACT_WRITE) || (sts.action == ACT_READ);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.action == ACT_ADVANCE) begin
					if (sts.grid_empty) begin
						state_d = ST_DONE;
					end else begin
						cmd.sweep_start = 1'b1;
						state_d         = ST_ADV_RD;
					end
				end else if (is_access && !sts.oor) begin
					cmd.acc_rd = 1'b1;
					state_d    = ST_ACC_MOD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ACC_MOD: begin
				cmd.acc_mod = 1'b1;
				state_d     = ST_DONE;
			end
			ST_ADV_RD: begin
				cmd.sweep_rd = 1'b1;
				if (sts.rd_last) begin
					state_d = ST_ADV_DRAIN;
				end
			end
			ST_ADV_DRAIN: begin
				state_d = ST_ADV_FLUSH;
			end
			ST_ADV_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_DECODE))
		else $error("accepted item not decoded");

	a_flush_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV_FLUSH) |-> ($past(state_q) == ST_ADV_DRAIN))
		else $error("sweep flush without drain");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && (state_q == ST_DONE)) |=> (state_q == ST_DONE))
		else $error("result overwritten before transfer");

	a_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_mod |-> ($past(cmd.acc_rd) && !cmd.sweep_rd))
		else $error("cell access without its row fetch");

endmodule

`default_nettype wire

>>> rtl/life_generation_step.sv
// Conway life (b3/s23) on a bounded grid held one row per memory word. A cell read
// or write runs through accept, decode and row fetch, row merge and write back (a
// read takes the cell from the fetched row instead), and result load. An out-of-range
// access, the unused action code and an advance on an empty grid run through accept,
// decode and result load. An advance sweeps the active height: it reads one row per
// cycle into a three-row window and writes each new row back once the row below it
// has entered the window (zeros below the last row), so the single read and single
// write port of the row memory set the pace. Per-row valid flops make the store read
// as dead after reset with no clearing pass. One item is worked at a time; the next
// transfer is taken as soon as the result sits in the output register.
// depends on lgs_pkg, lgs_ctrl, lgs_datapath, lgs_ram
`default_nettype none

module life_generation_step #(
	parameter int MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// action[1:0], row[7:2], col[13:8], alive_in[14], zero[15]
	input  wire logic [lgs_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// cell_alive[0], out_of_range[1], zero[7:2]
	output logic [lgs_pkg::M_TDATA_W-1:0]       m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [lgs_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [lgs_pkg::REG_W-1:0]      cfg_data
);
	import lgs_pkg::*;

	lgs_cmd_t cmd;
	lgs_sts_t sts;

	lgs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	lgs_datapath #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cfg_we  (cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire
